### rtl/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

	// input word: load a new value or step the scan
	typedef struct packed {
		logic        operation;
		logic [15:0] value;
		logic        advertising;
	} in_word_t;

	typedef struct packed {
		logic        word_valid;
		logic [15:0] scan_word;
		logic        blink_led;
	} out_word_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef logic [7:0] seg_t;

	localparam int   MAX_DIGITS = 4;
	localparam seg_t SEG_BLANK  = 8'hFF;

	// register index as decoded from the word address
	localparam logic REG_BLINK_LIMIT = 1'b0;

	localparam logic [7:0] BLINK_LIMIT_RESET = 8'd100;

	// one-hot digit select, high byte of each scan word
	localparam logic [7:0] DIGIT_SELECT [MAX_DIGITS] = '{8'h10, 8'h20, 8'h40, 8'h80};

	// value / 10^k as (value * mult) >> shift, exact for every 16-bit value
	localparam logic [16:0] RECIP_MULT [1:MAX_DIGITS] =
		'{17'd52429, 17'd83887, 17'd67109, 17'd107375};
	localparam int RECIP_SHIFT [1:MAX_DIGITS] = '{19, 23, 26, 30};

	// active-low segment patterns for decimal digits
	function automatic seg_t seg_encode(input logic [3:0] digit);
		seg_t seg;
		case (digit)
			4'd0:    seg = 8'h03;
			4'd1:    seg = 8'h9F;
			4'd2:    seg = 8'h25;
			4'd3:    seg = 8'h0D;
			4'd4:    seg = 8'h99;
			4'd5:    seg = 8'h49;
			4'd6:    seg = 8'h41;
			4'd7:    seg = 8'h1F;
			4'd8:    seg = 8'h01;
			4'd9:    seg = 8'h09;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

`default_nettype wire

### rtl/ssd_divider.sv
`default_nettype none

module ssd_divider import ssd_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  wire logic [15:0]             value,
	output logic      [DIGITS:0][15:0]   quot
);

	assign quot[0] = value;

	// value / 10^k by constant reciprocal, one independent product per digit
	for (genvar k = 1; k <= DIGITS; k++) begin : g_quot
		logic [33:0] prod;
		assign prod    = 34'(value) * 34'(RECIP_MULT[k]);
		assign quot[k] = 16'(prod >> RECIP_SHIFT[k]);
	end

endmodule

`default_nettype wire

### rtl/ssd_segment_enc.sv
`default_nettype none

module ssd_segment_enc import ssd_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  wire logic [DIGITS:0][15:0]   quot,
	output seg_t      [DIGITS-1:0]       segs
);

	for (genvar k = 0; k < DIGITS; k++) begin : g_digit
		logic [15:0] ten_next;
		logic [15:0] rem;
		logic        blank;

		// digit k = q[k] - 10 * q[k+1]
		assign ten_next = (quot[k+1] << 3) + (quot[k+1] << 1);
		assign rem      = quot[k] - ten_next;
		// blank above the most significant digit; lowest digit always shows
		assign blank    = (k != 0) && (quot[k] == 16'd0);
		assign segs[k]  = blank ? SEG_BLANK : seg_encode(rem[3:0]);
	end

endmodule

`default_nettype wire

### rtl/seven_segment_scan_driver_unit.sv
// A word taken into the input register moves to the result register once the
// output is free. Throughput: one word per cycle while out_stall is low;
// the decimal conversion (constant reciprocal multiplies, digit extraction,
// segment lookup) sits between the input register and the result register.
// Reset: pipeline empty, all digits blank, scan at digit 0, LED off,
// blink counter cleared, blink limit 100.
`default_nettype none

module seven_segment_scan_driver_unit import ssd_pkg::*; #(
	parameter int DIGITS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_word_t    in_data,

	output logic             out_valid,
	input  wire logic        out_stall,
	output out_word_t        out_data,

	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	// pipeline
	logic                    valid_s1;
	in_word_t                word_s1;
	logic                    out_valid_q;
	out_word_t               out_q;

	// display and blink state
	seg_t                    seg_q [DIGITS];
	logic [IDX_W-1:0]        idx_q;
	logic [7:0]              blink_count_q;
	logic                    led_q;
	logic [7:0]              blink_limit_q;

	logic                    out_free, s1_free;
	logic                    adv1, in_take;
	logic [DIGITS:0][15:0]   quot_d;
	seg_t [DIGITS-1:0]       seg_new;
	logic [IDX_W-1:0]        idx_next;
	logic [7:0]              cnt_inc;
	logic                    blink_wrap;
	logic                    led_next;
	logic                    is_tick;
	out_word_t               result;
	logic                    cfg_write;

	ssd_divider #(.DIGITS(DIGITS)) u_div (
		.value (word_s1.value),
		.quot  (quot_d)
	);

	ssd_segment_enc #(.DIGITS(DIGITS)) u_enc (
		.quot (quot_d),
		.segs (seg_new)
	);

	// flow control: the input register moves when the result register frees up
	assign out_free = !out_valid_q || !out_stall;
	assign s1_free  = !valid_s1 || out_free;
	assign adv1     = valid_s1 && out_free;
	assign in_stall = !s1_free;
	assign in_take  = in_valid && s1_free;

	assign is_tick    = (word_s1.operation == OP_TICK);
	assign idx_next   = (idx_q == IDX_W'(DIGITS - 1)) ? '0 : idx_q + 1'b1;
	assign cnt_inc    = blink_count_q + 8'd1;
	assign blink_wrap = cnt_inc > blink_limit_q;
	assign led_next   = blink_wrap ? ~led_q : led_q;

	always_comb begin
		result.word_valid = is_tick;
		result.scan_word  = is_tick ? {DIGIT_SELECT[idx_q], seg_q[idx_q]} : 16'h0000;
		result.blink_led  = (is_tick && word_s1.advertising) ? led_next : led_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_free) begin
				valid_s1 <= in_take;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= in_data;
		end
		if (adv1) begin
			out_q <= result;
		end
	end

	// commit state as each word leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIGITS; k++) begin
				seg_q[k] <= SEG_BLANK;
			end
			idx_q         <= '0;
			blink_count_q <= 8'd0;
			led_q         <= 1'b0;
		end else if (adv1) begin
			if (!is_tick) begin
				for (int k = 0; k < DIGITS; k++) begin
					seg_q[k] <= seg_new[k];
				end
			end else begin
				idx_q <= idx_next;
				if (word_s1.advertising) begin
					blink_count_q <= blink_wrap ? 8'd0 : cnt_inc;
					led_q         <= led_next;
				end
			end
		end
	end

	// configuration
	assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BLINK_LIMIT);
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_BLINK_LIMIT) ? {24'd0, blink_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_limit_q <= BLINK_LIMIT_RESET;
		end else if (cfg_write) begin
			blink_limit_q <= pwdata[7:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

### rtl/ssd_checker.sv
`default_nettype none

module ssd_checker import ssd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_stall,
	input wire out_word_t out_data
);

	logic [7:0] seg;
	assign seg = out_data.scan_word[7:0];

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// load results carry no scan word
	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.word_valid |-> out_data.scan_word == 16'h0000)
		else $error("load result carries a scan word");

	// scan words select exactly one digit
	a_select: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.word_valid |->
			$onehot(out_data.scan_word[15:12]) && out_data.scan_word[11:8] == 4'h0)
		else $error("scan word digit select not one-hot");

	// segments are a digit pattern or blank
	a_segments: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.word_valid |->
			seg == 8'h03 || seg == 8'h9F || seg == 8'h25 || seg == 8'h0D ||
			seg == 8'h99 || seg == 8'h49 || seg == 8'h41 || seg == 8'h1F ||
			seg == 8'h01 || seg == 8'h09 || seg == SEG_BLANK)
		else $error("scan word holds an unknown segment pattern");

endmodule

bind seven_segment_scan_driver_unit ssd_checker u_ssd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

`default_nettype wire

### verif/scan_word_checker.sv
`timescale 1ns / 100ps

module scan_word_checker import ssd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_word_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int unsigned mismatches,
	output int unsigned words_in_flight
);

	localparam logic [2:0] BLINK_LIMIT_ADDR = {REG_BLINK_LIMIT, 2'b00};

	// active-low patterns, digits 0 through 9
	localparam seg_t DIGIT_SEGMENTS [10] = '{
		8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99, 8'h49, 8'h41, 8'h1F, 8'h01, 8'h09
	};

	logic [15:0] shown_words [MAX_DIGITS];
	logic [1:0]  scan_pos;
	logic [7:0]  blink_ticks;
	logic        led_on;
	logic [7:0]  blink_limit;
	out_word_t   expected_words [$];

	task automatic show_value(input logic [15:0] value);
		int unsigned rest;
		bit          blank;
		int          k;
		rest  = value;
		blank = 1'b0;
		for (k = 0; k < MAX_DIGITS; k++) begin
			if (blank) begin
				shown_words[k][7:0] = SEG_BLANK;
			end else begin
				shown_words[k][7:0] = DIGIT_SEGMENTS[rest % 10];
				rest  = rest / 10;
				blank = (rest == 0);
			end
		end
	endtask

	task automatic predict_scan(input in_word_t w);
		out_word_t res;
		res = '0;
		if (op_t'(w.operation) == OP_LOAD) begin
			show_value(w.value);
		end else begin
			res.word_valid = 1'b1;
			res.scan_word  = shown_words[scan_pos];
			scan_pos = (scan_pos == MAX_DIGITS - 1) ? 2'd0 : scan_pos + 2'd1;
			if (w.advertising) begin
				blink_ticks = blink_ticks + 8'd1;
				if (blink_ticks > blink_limit) begin
					led_on      = ~led_on;
					blink_ticks = 8'd0;
				end
			end
		end
		res.blink_led = led_on;
		expected_words.push_back(res);
	endtask

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		if (!arst_n) begin
			for (int k = 0; k < MAX_DIGITS; k++)
				shown_words[k] = {DIGIT_SELECT[k], SEG_BLANK};
			scan_pos    = '0;
			blink_ticks = '0;
			led_on      = 1'b0;
			blink_limit = BLINK_LIMIT_RESET;
			expected_words.delete();
			mismatches  = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == BLINK_LIMIT_ADDR)
				blink_limit = pwdata[7:0];
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$error("unexpected word %0h", out_data);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					check_field("word_valid", want.word_valid, out_data.word_valid);
					check_field("scan_word", want.scan_word, out_data.scan_word);
					check_field("blink_led", want.blink_led, out_data.blink_led);
				end
			end
			if (in_valid && !in_stall)
				predict_scan(in_data);
		end
		words_in_flight = expected_words.size();
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ssd_pkg::*;

	localparam logic [2:0]  BLINK_LIMIT_ADDR = {REG_BLINK_LIMIT, 2'b00};
	localparam int unsigned CYCLE_LIMIT      = 200000;
	localparam int unsigned NORMAL_IDLE_PCT  = 26;
	localparam logic [15:0] CORNER_VALUES [12] = '{
		16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd305, 16'd999,
		16'd1000, 16'd9999, 16'd10000, 16'd65535
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	in_word_t    in_data   = '0;
	logic        out_stall = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic        in_stall;
	logic        out_valid;
	out_word_t   out_data;
	logic [31:0] prdata;
	logic        pready;

	int unsigned mismatches;
	int unsigned words_in_flight;
	int unsigned idle_pct = NORMAL_IDLE_PCT;
	int unsigned cycles   = 0;

	always #5 clk = ~clk;

	seven_segment_scan_driver_unit #(.DIGITS(MAX_DIGITS)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	scan_word_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatches     (mismatches),
		.words_in_flight(words_in_flight)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic in_word_t scan_item(input op_t op, input logic [15:0] value,
			input logic adv);
		in_word_t w;
		w.operation   = op;
		w.value       = value;
		w.advertising = adv;
		return w;
	endfunction

	function automatic logic [15:0] pick_value();
		case ($urandom_range(5))
			0:       return CORNER_VALUES[$urandom_range(11)];
			1, 2:    return 16'($urandom_range(9999));
			3:       return 16'($urandom_range(99));
			default: return 16'($urandom_range(65535));
		endcase
	endfunction

	// leaves valid high after acceptance so back-to-back words need no gap
	task automatic send_word(input in_word_t w);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_random(input int unsigned count, input int unsigned tick_pct,
			input int unsigned adv_pct);
		op_t op;
		repeat (count) begin
			op = ($urandom_range(99) < tick_pct) ? OP_TICK : OP_LOAD;
			send_word(scan_item(op, pick_value(), $urandom_range(99) < adv_pct));
		end
	endtask

	// hold off until every word sent has come back
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (words_in_flight != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_blink_limit(input logic [7:0] limit);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= BLINK_LIMIT_ADDR;
		pwdata  <= {24'd0, limit};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic show_and_scan(input logic [15:0] value, input logic adv);
		send_word(scan_item(OP_LOAD, value, ~adv));
		repeat (MAX_DIGITS) send_word(scan_item(OP_TICK, ~value, adv));
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blank words straight out of reset, then full rotations
		repeat (MAX_DIGITS) send_word(scan_item(OP_TICK, 16'hFFFF, 1'b0));
		show_and_scan(16'd0, 1'b1);
		show_and_scan(16'd65535, 1'b0);
		show_and_scan(16'd9999, 1'b1);
		send_word(scan_item(OP_LOAD, 16'd1234, 1'b1));
		show_and_scan(16'd7, 1'b1);
		wait_drained();

		write_blink_limit(8'd0);
		send_random(40, 60, 70);
		wait_drained();

		write_blink_limit(8'd3);
		send_random(40, 60, 70);
		wait_drained();

		// long runs of advertising ticks so the wide limits get crossed
		write_blink_limit(8'd254);
		send_random(300, 92, 97);
		wait_drained();

		write_blink_limit(8'd255);
		send_random(300, 92, 97);
		wait_drained();

		write_blink_limit(8'($urandom_range(2, 20)));
		send_random(40, 60, 70);
		wait_drained();

		idle_pct = 0;
		write_blink_limit(8'd1);
		send_random(70, 70, 80);
		wait_drained();
		idle_pct = NORMAL_IDLE_PCT;

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
